// ===== sv/tabx_pkg.sv =====
// tabx_pkg: shared constants, codes and types of the tab expander.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package tabx_pkg;

	// Field and state widths
	localparam int CHAR_W     = 8;
	localparam int REP_W      = 8;
	localparam int COL_W      = 16;
	localparam int STOP_W     = 8;
	localparam int MAX_STOPS  = 32;
	localparam int IDX_W      = $clog2(MAX_STOPS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int NUM_WORDS  = (MAX_STOPS * STOP_W) / CFG_DATA_W;
	localparam int DIV_STEPS  = COL_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	// Item queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [COL_W-1:0]      COL_MAX      = '1;
	localparam logic [CFG_DATA_W-1:0] DEFAULT_STOP = 64'd8;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAST_STOP = 3'd0,
		REG_WORD_A    = 3'd1,
		REG_WORD_B    = 3'd2,
		REG_WORD_C    = 3'd3,
		REG_WORD_D    = 3'd4
	} reg_idx_t;

	// Class of an input byte, decided in the front
	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_TAB,
		KIND_BACK,
		KIND_LINE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
	} item_t;

	// One side of the item queue
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_word_t;

	// Tab stop configuration seen by the back
	typedef struct packed {
		logic [IDX_W-1:0]                  last_idx;
		logic [MAX_STOPS-1:0][STOP_W-1:0] stops;
	} stop_cfg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SCAN,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

// ===== sv/tabx_if.sv =====
// tabx_if: valid/ready channel interfaces for text bytes and expanded results.
// Depends on tabx_pkg for the field widths.
`default_nettype none

interface tabx_in_if;
	logic                           valid;
	logic                           ready;
	logic [tabx_pkg::CHAR_W-1:0]    in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

interface tabx_out_if;
	logic                           valid;
	logic                           ready;
	logic [tabx_pkg::CHAR_W-1:0]    out_char;
	logic [tabx_pkg::REP_W-1:0]     repeat_res;

	modport source (output valid, output out_char, output repeat_res, input ready);
	modport sink (input valid, input out_char, input repeat_res, output ready);
endinterface

`default_nettype wire

// ===== sv/tab_expander_unit.sv =====
// Tab expander, a byte of text in and one (character, repeat count) result out per
// byte. A plain byte, backspace or line end passes the front register, the queue,
// the back end's idle and emit states and the output register. A tab with uniform
// nonzero stops runs a 16-step serial remainder unit on the column; a tab with a
// stop list scans one stop per cycle, up to the last stop index. The back end works
// one item at a time because each result depends on the column the previous one
// left; a two-entry queue and a registered front let the input keep transferring
// meanwhile, and the output register lets the back end finish while a result waits
// to be taken. Configuration is to be written only while the block is idle;
// the block itself does not enforce this.
// Depends on tabx_pkg, tabx_if, tabx_front, tabx_queue and tabx_back.
`default_nettype none

module tab_expander_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	tabx_in_if.sink                             text,
	tabx_out_if.source                          result,
	input  wire                                 cfg_we,
	input  wire [tabx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [tabx_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [tabx_pkg::IDX_W-1:0]                             last_q;
	logic [tabx_pkg::NUM_WORDS-1:0][tabx_pkg::CFG_DATA_W-1:0] stops_q;
	tabx_pkg::stop_cfg_t                                    cfg;
	tabx_pkg::q_word_t                                      push;
	logic                                                   push_ready;
	tabx_pkg::q_word_t                                      pop;
	logic                                                   pop_ready;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			stops_q <= (tabx_pkg::NUM_WORDS * tabx_pkg::CFG_DATA_W)'(tabx_pkg::DEFAULT_STOP);
		end else if (cfg_we) begin
			unique case (tabx_pkg::reg_idx_t'(cfg_index))
				tabx_pkg::REG_LAST_STOP: last_q     <= cfg_data[tabx_pkg::IDX_W-1:0];
				tabx_pkg::REG_WORD_A:    stops_q[0] <= cfg_data;
				tabx_pkg::REG_WORD_B:    stops_q[1] <= cfg_data;
				tabx_pkg::REG_WORD_C:    stops_q[2] <= cfg_data;
				tabx_pkg::REG_WORD_D:    stops_q[3] <= cfg_data;
				default: begin
					last_q <= last_q;
				end
			endcase
		end
	end

	// Stop 0 sits in the lowest byte of the first word
	assign cfg.last_idx = last_q;
	assign cfg.stops    = stops_q;

	tabx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.push       (push),
		.push_ready (push_ready)
	);

	tabx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	tabx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop       (pop),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== sv/tabx_front.sv =====
// tabx_front: accepts text bytes and tags each with its class.
// Depends on tabx_pkg and tabx_in_if; feeds tabx_queue.
`default_nettype none

module tabx_front (
	input  wire                     clk,
	input  wire                     arst_n,
	tabx_in_if.sink                 text,
	output tabx_pkg::q_word_t       push,
	input  wire                     push_ready
);

	logic              v_s1;
	tabx_pkg::item_t   item_s1;
	logic              take;
	tabx_pkg::kind_t   kind;

	// Classify the incoming byte
	always_comb begin
		priority if (text.in_char == tabx_pkg::CH_TAB) begin
			kind = tabx_pkg::KIND_TAB;
		end else if (text.in_char == tabx_pkg::CH_BS) begin
			kind = tabx_pkg::KIND_BACK;
		end else if (text.in_char == tabx_pkg::CH_LF || text.in_char == tabx_pkg::CH_CR) begin
			kind = tabx_pkg::KIND_LINE;
		end else begin
			kind = tabx_pkg::KIND_PLAIN;
		end
	end

	// Take a byte when the stage is empty or drains this cycle
	assign text.ready = !v_s1 || push_ready;
	assign take       = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{kind: kind, ch: text.in_char};
		end
	end

	assign push.valid = v_s1;
	assign push.item  = item_s1;

endmodule

`default_nettype wire

// ===== sv/tabx_queue.sv =====
// tabx_queue: short item queue that decouples the front from the back.
// Depends on tabx_pkg for the item type and depth.
`default_nettype none

module tabx_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tabx_pkg::q_word_t       push,
	output logic                    push_ready,
	output tabx_pkg::q_word_t       pop,
	input  wire                     pop_ready
);

	tabx_pkg::item_t                    mem_q [tabx_pkg::QUEUE_DEPTH];
	logic [tabx_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [tabx_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [tabx_pkg::QPTR_W:0]          count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = count_q != (tabx_pkg::QPTR_W + 1)'(tabx_pkg::QUEUE_DEPTH);
	assign pop.valid  = count_q != '0;
	assign pop.item   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tabx_back.sv =====
// tabx_back: keeps the output column and turns each queued item into a result.
// Depends on tabx_pkg and tabx_out_if; holds the serial remainder unit and stop scan.
`default_nettype none

module tabx_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tabx_pkg::stop_cfg_t     cfg,
	input  tabx_pkg::q_word_t       pop,
	output logic                    pop_ready,
	tabx_out_if.source              result
);

	tabx_pkg::back_state_t              state_q, state_d;
	logic [tabx_pkg::COL_W-1:0]         col_q, col_d;
	logic                               col_we;
	logic [tabx_pkg::CHAR_W-1:0]        ch_q, ch_d;
	logic                               ch_we;
	logic [tabx_pkg::REP_W-1:0]         rep_q, rep_d;
	logic                               rep_we;
	logic [tabx_pkg::COL_W-1:0]         divd_q;
	logic [tabx_pkg::STOP_W-1:0]        rem_q;
	logic [tabx_pkg::CNT_W-1:0]         cnt_q;
	logic [tabx_pkg::IDX_W-1:0]         idx_q;
	logic                               div_start;
	logic                               scan_start;
	logic                               scan_next;
	logic                               emit_load;
	logic                               out_v_q;
	logic [tabx_pkg::CHAR_W-1:0]        out_ch_q;
	logic [tabx_pkg::REP_W-1:0]         out_rep_q;

	logic [tabx_pkg::IDX_W-1:0]         last_idx;
	logic                               uniform;
	logic [tabx_pkg::STOP_W-1:0]        stop0;
	logic [tabx_pkg::STOP_W-1:0]        cur_stop;
	logic [tabx_pkg::STOP_W:0]          trial;
	logic [tabx_pkg::STOP_W-1:0]        rem_nx;
	logic [tabx_pkg::REP_W-1:0]         rep_div;
	logic [tabx_pkg::REP_W-1:0]         rep_scan;
	logic                               slot_free;

	// Add a repeat count to the column, stopping at the top
	function automatic logic [tabx_pkg::COL_W-1:0] col_add(
		input logic [tabx_pkg::COL_W-1:0] col,
		input logic [tabx_pkg::REP_W-1:0] rep
	);
		logic [tabx_pkg::COL_W:0] sum;
		sum = {1'b0, col} + {{(tabx_pkg::COL_W + 1 - tabx_pkg::REP_W){1'b0}}, rep};
		return sum[tabx_pkg::COL_W] ? tabx_pkg::COL_MAX : sum[tabx_pkg::COL_W-1:0];
	endfunction

	// Stop list view; an index past the list size falls back to its last entry
	always_comb begin
		if ({1'b0, cfg.last_idx} >= (tabx_pkg::IDX_W + 1)'(tabx_pkg::MAX_STOPS)) begin
			last_idx = tabx_pkg::IDX_W'(tabx_pkg::MAX_STOPS - 1);
		end else begin
			last_idx = cfg.last_idx;
		end
	end

	assign uniform  = last_idx == '0;
	assign stop0    = cfg.stops[0];
	assign cur_stop = cfg.stops[idx_q];

	// One restoring remainder step per cycle: column mod stop 0
	assign trial   = {rem_q, divd_q[tabx_pkg::COL_W-1]};
	assign rem_nx  = (trial >= {1'b0, stop0}) ? tabx_pkg::STOP_W'(trial - {1'b0, stop0})
	                                          : trial[tabx_pkg::STOP_W-1:0];
	assign rep_div  = stop0 - rem_nx;
	assign rep_scan = cur_stop - col_q[tabx_pkg::STOP_W-1:0];

	assign slot_free = !out_v_q || result.ready;

	// Next state and datapath controls
	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		col_we     = 1'b0;
		col_d      = col_q;
		ch_we      = 1'b0;
		ch_d       = pop.item.ch;
		rep_we     = 1'b0;
		rep_d      = tabx_pkg::REP_W'(1);
		div_start  = 1'b0;
		scan_start = 1'b0;
		scan_next  = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			tabx_pkg::B_IDLE: begin
				pop_ready = 1'b1;
				if (pop.valid) begin
					ch_we  = 1'b1;
					rep_we = 1'b1;
					unique case (pop.item.kind)
						tabx_pkg::KIND_PLAIN: begin
							col_we  = 1'b1;
							col_d   = col_add(col_q, tabx_pkg::REP_W'(1));
							state_d = tabx_pkg::B_EMIT;
						end
						tabx_pkg::KIND_BACK: begin
							col_we  = 1'b1;
							col_d   = (col_q == '0) ? '0 : col_q - 1'b1;
							state_d = tabx_pkg::B_EMIT;
						end
						tabx_pkg::KIND_LINE: begin
							col_we  = 1'b1;
							col_d   = '0;
							state_d = tabx_pkg::B_EMIT;
						end
						tabx_pkg::KIND_TAB: begin
							ch_d = tabx_pkg::CH_SPACE;
							priority if (!uniform) begin
								scan_start = 1'b1;
								state_d    = tabx_pkg::B_SCAN;
							end else if (stop0 != '0) begin
								div_start = 1'b1;
								state_d   = tabx_pkg::B_DIV;
							end else begin
								col_we  = 1'b1;
								col_d   = col_add(col_q, tabx_pkg::REP_W'(1));
								state_d = tabx_pkg::B_EMIT;
							end
						end
						default: begin
							state_d = tabx_pkg::B_IDLE;
						end
					endcase
				end
			end
			tabx_pkg::B_DIV: begin
				if (cnt_q == tabx_pkg::CNT_W'(tabx_pkg::DIV_STEPS - 1)) begin
					rep_we  = 1'b1;
					rep_d   = rep_div;
					col_we  = 1'b1;
					col_d   = col_add(col_q, rep_div);
					state_d = tabx_pkg::B_EMIT;
				end
			end
			tabx_pkg::B_SCAN: begin
				priority if ({{(tabx_pkg::COL_W - tabx_pkg::STOP_W){1'b0}}, cur_stop} > col_q)
				begin
					rep_we  = 1'b1;
					rep_d   = rep_scan;
					col_we  = 1'b1;
					col_d   = col_add(col_q, rep_scan);
					state_d = tabx_pkg::B_EMIT;
				end else if (idx_q == last_idx) begin
					rep_we  = 1'b1;
					col_we  = 1'b1;
					col_d   = col_add(col_q, tabx_pkg::REP_W'(1));
					state_d = tabx_pkg::B_EMIT;
				end else begin
					scan_next = 1'b1;
				end
			end
			tabx_pkg::B_EMIT: begin
				if (slot_free) begin
					emit_load = 1'b1;
					state_d   = tabx_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = tabx_pkg::B_IDLE;
			end
		endcase
	end

	// Control state: sequencer, column, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tabx_pkg::B_IDLE;
			col_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (col_we) begin
				col_q <= col_d;
			end
			if (emit_load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Working registers of the remainder unit and stop scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (div_start) begin
				cnt_q <= '0;
			end else if (state_q == tabx_pkg::B_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (scan_start) begin
				idx_q <= '0;
			end else if (scan_next) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (div_start) begin
			divd_q <= col_q;
			rem_q  <= '0;
		end else if (state_q == tabx_pkg::B_DIV) begin
			divd_q <= {divd_q[tabx_pkg::COL_W-2:0], 1'b0};
			rem_q  <= rem_nx;
		end
		if (ch_we) begin
			ch_q <= ch_d;
		end
		if (rep_we) begin
			rep_q <= rep_d;
		end
		if (emit_load) begin
			out_ch_q  <= ch_q;
			out_rep_q <= rep_q;
		end
	end

	assign result.valid      = out_v_q;
	assign result.out_char   = out_ch_q;
	assign result.repeat_res = out_rep_q;

`ifndef SYNTHESIS
	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_rep_q != '0)
		else $error("result with zero repeat count");

	a_plain_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_ch_q != tabx_pkg::CH_SPACE |-> out_rep_q == tabx_pkg::REP_W'(1))
		else $error("non-space result repeated");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tabx_pkg::B_IDLE && pop.valid && pop.item.kind == tabx_pkg::KIND_LINE
		|=> col_q == '0)
		else $error("line end did not clear the column");

	a_back_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tabx_pkg::B_IDLE && pop.valid && pop.item.kind == tabx_pkg::KIND_BACK
		&& col_q != '0 |=> col_q == $past(col_q) - 1'b1)
		else $error("backspace did not lower the column by one");

	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tabx_pkg::B_IDLE |-> !pop_ready)
		else $error("queue popped while an item is in work");
`endif

endmodule

`default_nettype wire
